@@ design/rshd_pkg.sv @@
// ----------------------------------------------------------------------------
// rshd_pkg
// widths, types and register codes for the ray/sphere hit distance core
// ----------------------------------------------------------------------------
`default_nettype none

package rshd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW          = COORD_WIDTH;
    localparam int DIRW        = 16;              // Q1.14 direction component
    localparam int MAXDW       = 32;              // limit and distance, Q16.16
    localparam int FRAC_DIR    = 14;
    localparam int CFG_IDX_W   = 8;

    localparam int DW    = CW + 1;                // center - origin
    localparam int SQW   = 2 * DW;                // one squared component
    localparam int DIR2W = SQW + 2;               // |D|^2
    localparam int PUW   = DIRW + DW;             // one dir * D product
    localparam int DISW  = PUW + 2;               // projection, Q.30
    localparam int PW    = DISW - 1 - FRAC_DIR;   // positive projection, Q20.16
    localparam int PLW   = (PW + 1) / 2;
    localparam int PHW   = PW - PLW;
    localparam int PSQW  = 2 * PW;                // projection squared
    localparam int RW    = CW - 1;                // radius
    localparam int R2W   = 2 * RW;                // radius squared
    localparam int SW    = PSQW + 2;              // radicand, also a^2 signed
    localparam int RTW   = SW / 2;                // root
    localparam int DSTW  = RTW + 2;               // signed distance

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(3);

    localparam logic [RW-1:0] RADIUS_RESET = RW'(65536);

    // what rides alongside the radicand through the root pipeline
    typedef struct packed {
        logic             miss;
        logic [PW-1:0]    proj;
        logic             lim_en;
        logic [MAXDW-1:0] max_dist;
    } side_t;

endpackage

`default_nettype wire

@@ design/rshd_ray_if.sv @@
// ----------------------------------------------------------------------------
// rshd_ray_if
// ray input channel: origin, direction and optional distance limit
// ----------------------------------------------------------------------------
`default_nettype none

interface rshd_ray_if;
    import rshd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CW-1:0]   origin_x;
    logic signed [CW-1:0]   origin_y;
    logic signed [CW-1:0]   origin_z;
    logic signed [DIRW-1:0] dir_x;
    logic signed [DIRW-1:0] dir_y;
    logic signed [DIRW-1:0] dir_z;
    logic                   limit_enable;
    logic [MAXDW-1:0]       max_distance;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    limit_enable, max_distance, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  limit_enable, max_distance, output ready);
endinterface

`default_nettype wire

@@ design/rshd_hit_if.sv @@
// ----------------------------------------------------------------------------
// rshd_hit_if
// result channel: hit flag and entry distance
// ----------------------------------------------------------------------------
`default_nettype none

interface rshd_hit_if;
    import rshd_pkg::*;

    logic             valid;
    logic             ready;
    logic             is_hit;
    logic [MAXDW-1:0] hit_distance;

    modport source (output valid, is_hit, hit_distance, input ready);
    modport sink (input valid, is_hit, hit_distance, output ready);
endinterface

`default_nettype wire

@@ design/rshd_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rshd_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface rshd_cfg_if;
    import rshd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/rshd_front.sv @@
// ----------------------------------------------------------------------------
// rshd_front
// six stage geometry pipe: D, products, dot sums, tests, p^2, radicand
// ----------------------------------------------------------------------------
`default_nettype none

module rshd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rshd_ray_if.sink                         ray,
    input  wire logic signed [rshd_pkg::CW-1:0]  center_x,
    input  wire logic signed [rshd_pkg::CW-1:0]  center_y,
    input  wire logic signed [rshd_pkg::CW-1:0]  center_z,
    input  wire logic [rshd_pkg::R2W-1:0]        r2,
    output logic                             dn_valid,
    input  wire logic                        dn_ready,
    output logic [rshd_pkg::SW-1:0]          dn_rad,
    output rshd_pkg::side_t                  dn_side
);
    import rshd_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    // stage 1
    logic signed [DW-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [DIRW-1:0] ux_reg, uy_reg, uz_reg;
    logic                   lim1_reg;
    logic [MAXDW-1:0]       maxd1_reg;
    // stage 2
    logic signed [SQW-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic signed [PUW-1:0]  pux_reg, puy_reg, puz_reg;
    logic                   lim2_reg;
    logic [MAXDW-1:0]       maxd2_reg;
    logic signed [SQW-1:0]  sqx_next, sqy_next, sqz_next;
    logic signed [PUW-1:0]  pux_next, puy_next, puz_next;
    // stage 3
    logic [DIR2W-1:0]       dir2_3_reg;
    logic signed [DISW-1:0] dis_reg;
    logic                   lim3_reg;
    logic [MAXDW-1:0]       maxd3_reg;
    logic signed [DISW-1:0] dis_next;
    // stage 4
    logic                   miss4_reg;
    logic [DIR2W-1:0]       dir2_4_reg;
    logic [PW-1:0]          p4_reg;
    logic [2*PLW-1:0]       pll_reg;
    logic [PLW+PHW-1:0]     plh_reg;
    logic [2*PHW-1:0]       phh_reg;
    logic                   lim4_reg;
    logic [MAXDW-1:0]       maxd4_reg;
    logic [PW-1:0]          p_next;
    logic                   miss4_next;
    // stage 5
    logic                   miss5_reg;
    logic [DIR2W-1:0]       dir2_5_reg;
    logic [PW-1:0]          p5_reg;
    logic [PSQW-1:0]        psq_reg;
    logic                   lim5_reg;
    logic [MAXDW-1:0]       maxd5_reg;
    logic [PSQW-1:0]        psq_next;
    // stage 6
    logic [SW-1:0]          rad_reg;
    side_t                  side_reg;
    logic signed [SW-1:0]   a2;
    logic signed [SW-1:0]   r2_s;
    side_t                  side_next;

    assign ld6 = !v6_reg || dn_ready;
    assign ld5 = !v5_reg || ld6;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign ray.ready = ld1;

    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign sqz_next = dz_reg * dz_reg;
    assign pux_next = ux_reg * dx_reg;
    assign puy_next = uy_reg * dy_reg;
    assign puz_next = uz_reg * dz_reg;
    assign dis_next = DISW'(pux_reg) + DISW'(puy_reg) + DISW'(puz_reg);

    // inside or on the sphere, or center behind or abeam of the origin
    assign miss4_next = !(DIR2W'(r2) < dir2_3_reg) || dis_reg[DISW-1] || (dis_reg == '0);
    assign p_next     = dis_reg[DISW-2:FRAC_DIR];

    assign psq_next = (PSQW'(phh_reg) << (2 * PLW)) + (PSQW'(plh_reg) << (PLW + 1))
                    + PSQW'(pll_reg);

    assign r2_s = $signed(SW'(r2));
    assign a2   = $signed(SW'(dir2_5_reg)) - $signed(SW'(psq_reg));

    always_comb
    begin
        side_next.miss     = miss5_reg || !(a2 < r2_s);
        side_next.proj     = p5_reg;
        side_next.lim_en   = lim5_reg;
        side_next.max_dist = maxd5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= ray.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
            if (ld6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            dx_reg    <= DW'(center_x) - DW'(ray.origin_x);
            dy_reg    <= DW'(center_y) - DW'(ray.origin_y);
            dz_reg    <= DW'(center_z) - DW'(ray.origin_z);
            ux_reg    <= ray.dir_x;
            uy_reg    <= ray.dir_y;
            uz_reg    <= ray.dir_z;
            lim1_reg  <= ray.limit_enable;
            maxd1_reg <= ray.max_distance;
        end
        if (ld2)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            sqz_reg   <= sqz_next;
            pux_reg   <= pux_next;
            puy_reg   <= puy_next;
            puz_reg   <= puz_next;
            lim2_reg  <= lim1_reg;
            maxd2_reg <= maxd1_reg;
        end
        if (ld3)
        begin
            // squares are never negative
            dir2_3_reg <= DIR2W'($unsigned(sqx_reg)) + DIR2W'($unsigned(sqy_reg))
                        + DIR2W'($unsigned(sqz_reg));
            dis_reg    <= dis_next;
            lim3_reg   <= lim2_reg;
            maxd3_reg  <= maxd2_reg;
        end
        if (ld4)
        begin
            miss4_reg  <= miss4_next;
            dir2_4_reg <= dir2_3_reg;
            p4_reg     <= p_next;
            pll_reg    <= p_next[PLW-1:0] * p_next[PLW-1:0];
            plh_reg    <= (PLW+PHW)'(p_next[PLW-1:0]) * (PLW+PHW)'(p_next[PW-1:PLW]);
            phh_reg    <= p_next[PW-1:PLW] * p_next[PW-1:PLW];
            lim4_reg   <= lim3_reg;
            maxd4_reg  <= maxd3_reg;
        end
        if (ld5)
        begin
            miss5_reg  <= miss4_reg;
            dir2_5_reg <= dir2_4_reg;
            p5_reg     <= p4_reg;
            psq_reg    <= psq_next;
            lim5_reg   <= lim4_reg;
            maxd5_reg  <= maxd4_reg;
        end
        if (ld6)
        begin
            rad_reg  <= SW'(r2_s - a2);
            side_reg <= side_next;
        end
    end

    assign dn_valid = v6_reg;
    assign dn_rad   = rad_reg;
    assign dn_side  = side_reg;

endmodule

`default_nettype wire

@@ design/rshd_sqrt.sv @@
// ----------------------------------------------------------------------------
// rshd_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rshd_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire logic [rshd_pkg::SW-1:0] up_rad,
    input  rshd_pkg::side_t             up_side,
    output logic                        dn_valid,
    input  wire logic                   dn_ready,
    output logic [rshd_pkg::RTW-1:0]    dn_root,
    output rshd_pkg::side_t             dn_side
);
    import rshd_pkg::*;

    logic          v_reg    [RTW];
    logic [SW-1:0] rem_reg  [RTW];
    logic [RTW-1:0] res_reg [RTW];
    side_t         side_reg [RTW];
    logic          ld       [RTW];

    genvar j;
    generate
        for (j = 0; j < RTW; j++)
        begin : g_stage
            localparam int K = RTW - 1 - j;
            logic           v_in;
            logic [SW-1:0]  rem_in;
            logic [RTW-1:0] res_in;
            side_t          side_in;
            logic [SW:0]    trial;
            logic           take;

            if (j == 0)
            begin : g_first
                assign v_in    = up_valid;
                assign rem_in  = up_rad;
                assign res_in  = '0;
                assign side_in = up_side;
            end
            else
            begin : g_next
                assign v_in    = v_reg[j-1];
                assign rem_in  = rem_reg[j-1];
                assign res_in  = res_reg[j-1];
                assign side_in = side_reg[j-1];
            end

            if (j == RTW - 1)
            begin : g_last
                assign ld[j] = !v_reg[j] || dn_ready;
            end
            else
            begin : g_mid
                assign ld[j] = !v_reg[j] || ld[j+1];
            end

            // (res + 2^k)^2 - res^2 against what is left of the radicand
            assign trial = ((SW+1)'(res_in) << (K + 1)) + ((SW+1)'(1) << (2 * K));
            assign take  = {1'b0, rem_in} >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[j] <= 1'b0;
                else if (ld[j])
                    v_reg[j] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (ld[j])
                begin
                    rem_reg[j]  <= take ? rem_in - trial[SW-1:0] : rem_in;
                    res_reg[j]  <= take ? (res_in | (RTW'(1) << K)) : res_in;
                    side_reg[j] <= side_in;
                end
            end
        end
    endgenerate

    assign up_ready = ld[0];
    assign dn_valid = v_reg[RTW-1];
    assign dn_root  = res_reg[RTW-1];
    assign dn_side  = side_reg[RTW-1];

endmodule

`default_nettype wire

@@ design/ray_sphere_hit_distance_core.sv @@
// a ray passes 6 geometry stages, 37 root stages and one output register on its way
//   to the result; one ray per cycle sustained while hit.ready stays high
// the root pipeline, one result bit per stage, sets the depth
// stalls collapse bubbles stage by stage; ready drops only when every stage is full
// reset clears all valid bits, centers to zero and radius to 1.0
// ----------------------------------------------------------------------------
// ray_sphere_hit_distance_core
// geometric ray/sphere entry distance in fixed point with optional limit
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_hit_distance_core (
    input  wire logic clk,
    input  wire logic rst_n,
    rshd_ray_if.sink  ray,
    rshd_hit_if.source hit,
    rshd_cfg_if.sink  cfg
);
    import rshd_pkg::*;

    logic signed [CW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [R2W-1:0]       r2_reg;
    logic                 cfg_wr;

    logic                 fr_valid, fr_ready;
    logic [SW-1:0]        fr_rad;
    side_t                fr_side;
    logic                 sq_valid;
    logic [RTW-1:0]       sq_root;
    side_t                sq_side;

    logic                  out_ld;
    logic                  hit_valid_reg;
    logic                  is_hit_reg;
    logic [MAXDW-1:0]      dist_reg;
    logic signed [DSTW-1:0] raw_dist;
    logic                  over_limit;
    logic [MAXDW-1:0]      dist_sat;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            r2_reg       <= R2W'(RADIUS_RESET) * R2W'(RADIUS_RESET);
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                REG_CENTER_X: center_x_reg <= cfg.data;
                REG_CENTER_Y: center_y_reg <= cfg.data;
                REG_CENTER_Z: center_z_reg <= cfg.data;
                REG_RADIUS:   r2_reg <= R2W'(cfg.data[RW-1:0]) * R2W'(cfg.data[RW-1:0]);
                default: ;
            endcase
        end
    end

    rshd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .ray      (ray),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .r2       (r2_reg),
        .dn_valid (fr_valid),
        .dn_ready (fr_ready),
        .dn_rad   (fr_rad),
        .dn_side  (fr_side)
    );

    rshd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fr_valid),
        .up_ready (fr_ready),
        .up_rad   (fr_rad),
        .up_side  (fr_side),
        .dn_valid (sq_valid),
        .dn_ready (out_ld),
        .dn_root  (sq_root),
        .dn_side  (sq_side)
    );

    assign raw_dist   = $signed(DSTW'(sq_side.proj)) - $signed(DSTW'(sq_root));
    assign over_limit = sq_side.lim_en && !(raw_dist < $signed(DSTW'(sq_side.max_dist)));

    always_comb
    begin
        if (raw_dist[DSTW-1])
            dist_sat = '0;
        else if (|raw_dist[DSTW-2:MAXDW])
            dist_sat = '1;
        else
            dist_sat = raw_dist[MAXDW-1:0];
    end

    assign out_ld = !hit_valid_reg || hit.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_valid_reg <= 1'b0;
        else if (out_ld)
            hit_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            is_hit_reg <= !sq_side.miss && !over_limit;
            dist_reg   <= (sq_side.miss || over_limit) ? '0 : dist_sat;
        end
    end

    assign hit.valid        = hit_valid_reg;
    assign hit.is_hit       = is_hit_reg;
    assign hit.hit_distance = dist_reg;

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid && !hit.is_hit |-> hit.hit_distance == '0)
        else $error("miss word carries a distance");

    a_radius_sq : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && cfg.index == REG_RADIUS |=>
        r2_reg == R2W'($past(cfg.data[RW-1:0])) * R2W'($past(cfg.data[RW-1:0])))
        else $error("radius squared not updated");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> hit_valid_reg && sq_valid && fr_valid)
        else $error("input stalled with a bubble in the pipe");

endmodule

`default_nettype wire

@@ tb/sv/tb_ray_sphere_hit_distance_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_hit_distance_core
// checks entry distance and hit flag of the ray/sphere core against an
// independent fixed-point predictor, with random idling on both channels
// ----------------------------------------------------------------------------

class hit_scoreboard;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        radius;
    bit                 exp_hit[$];
    logic [31:0]        exp_dist[$];
    int                 errors;
    int                 hits;
    int                 misses;

    function void reset_regs();
        cx = 0;
        cy = 0;
        cz = 0;
        radius = 31'd65536;
    endfunction

    // floor square root of an unsigned 128-bit value
    function logic [63:0] floor_root(logic [127:0] s);
        logic [63:0]  res;
        logic [63:0]  c;
        logic [127:0] sq;
        res = 0;
        for (int i = 63; i >= 0; i--) begin
            c = res | (64'd1 << i);
            sq = {64'd0, c} * {64'd0, c};
            if (s >= sq)
                res = c;
        end
        return res;
    endfunction

    function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] oz, logic signed [15:0] ux,
                           logic signed [15:0] uy, logic signed [15:0] uz,
                           logic lim_en, logic [31:0] lim);
        logic signed [127:0] dx, dy, dz, len2, r2, proj, p16, a2, raw_dist;
        logic [127:0]        s;
        bit                  h;
        logic [31:0]         d;
        h = 0;
        d = 0;
        dx = 128'(cx) - 128'(ox);
        dy = 128'(cy) - 128'(oy);
        dz = 128'(cz) - 128'(oz);
        len2 = dx * dx + dy * dy + dz * dz;
        r2 = 128'({1'b0, radius}) * 128'({1'b0, radius});
        proj = 128'(ux) * dx + 128'(uy) * dy + 128'(uz) * dz;
        if (len2 > r2 && proj > 0) begin
            p16 = proj >>> 14;
            a2 = len2 - p16 * p16;
            if (a2 < r2) begin
                s = r2 - a2;
                raw_dist = p16 - 128'({64'd0, floor_root(s)});
                // a negative distance is below any limit
                if (!(lim_en && !(raw_dist < $signed(128'({96'd0, lim}))))) begin
                    h = 1;
                    if (raw_dist < 0)
                        d = 0;
                    else if (raw_dist > 128'h0ffff_ffff)
                        d = 32'hffff_ffff;
                    else
                        d = raw_dist[31:0];
                end
            end
        end
        exp_hit.push_back(h);
        exp_dist.push_back(d);
    endfunction

    function void check_result(logic got_hit, logic [31:0] got_dist);
        bit          h;
        logic [31:0] d;
        if (exp_hit.size() == 0) begin
            $display("%0t: result with nothing expected: hit %0b dist %h",
                     $realtime, got_hit, got_dist);
            errors++;
            return;
        end
        h = exp_hit.pop_front();
        d = exp_dist.pop_front();
        if (h) hits++; else misses++;
        if (got_hit !== h) begin
            $display("%0t: is_hit expected %0b actual %0b", $realtime, h, got_hit);
            errors++;
        end
        if (got_dist !== d) begin
            $display("%0t: hit_distance expected %h actual %h", $realtime, d, got_dist);
            errors++;
        end
    endfunction
endclass

module tb_ray_sphere_hit_distance_core;
    import rshd_pkg::*;

    logic clk;
    logic rst_n;

    rshd_ray_if ray ();
    rshd_hit_if hit ();
    rshd_cfg_if cfg ();

    ray_sphere_hit_distance_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .ray   (ray.sink),
        .hit   (hit.source),
        .cfg   (cfg.sink)
    );

    hit_scoreboard sb;
    int  hold_off;      // long receiver stall, counted in the sink process
    bit  stall_free;    // no random idling on either side
    int  sent;

    initial
    begin
        clk = 0;
        forever
        begin
            #1 clk = 1;
            #1 clk = 0;
        end
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function logic signed [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'($urandom);
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.index <= idx;
        cfg.data  <= value;
        cfg.valid <= 1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 0;
        case (idx)
            REG_CENTER_X: sb.cx = value;
            REG_CENTER_Y: sb.cy = value;
            REG_CENTER_Z: sb.cz = value;
            REG_RADIUS:   sb.radius = value[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                            logic signed [31:0] oz, logic signed [15:0] ux,
                            logic signed [15:0] uy, logic signed [15:0] uz,
                            logic lim_en, logic [31:0] lim);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // valid stays up between back to back words
        if (gap > 0) begin
            ray.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        ray.origin_x <= ox;
        ray.origin_y <= oy;
        ray.origin_z <= oz;
        ray.dir_x <= ux;
        ray.dir_y <= uy;
        ray.dir_z <= uz;
        ray.limit_enable <= lim_en;
        ray.max_distance <= lim;
        ray.valid <= 1;
        do @(posedge clk); while (!ray.ready);
        sb.note_ray(ox, oy, oz, ux, uy, uz, lim_en, lim);
        sent++;
    endtask

    task automatic send_random();
        logic signed [31:0] ox, oy, oz;
        logic signed [15:0] ux, uy, uz;
        // most rays aimed at the sphere so that the hit path gets exercised
        if ($urandom_range(0, 3) != 0) begin
            ux = 16'($signed($urandom_range(0, 32768)) - 16384);
            uy = 16'($signed($urandom_range(0, 32768)) - 16384);
            uz = 16'($signed($urandom_range(0, 16384)) - 0);
            ox = sb.cx - 32'($signed(ux) * $urandom_range(2, 40)) * 4
                 + 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            oy = sb.cy - 32'($signed(uy) * $urandom_range(2, 40)) * 4;
            oz = sb.cz - 32'($signed(uz) * $urandom_range(2, 40)) * 4;
        end else begin
            ox = rand_coord();
            oy = rand_coord();
            oz = rand_coord();
            ux = rand_dir();
            uy = rand_dir();
            uz = rand_dir();
        end
        send_ray(ox, oy, oz, ux, uy, uz, 1'($urandom),
                 $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50 << 16));
    endtask

    task automatic drain();
        ray.valid <= 0;
        while (sb.exp_hit.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // result side
    initial
    begin
        int wait_n;
        hit.ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0) begin
                hit.ready <= 0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            wait_n = stall_free ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            if (wait_n > 0) begin
                hit.ready <= 0;
                repeat (wait_n) @(posedge clk);
            end
            hit.ready <= 1;
            do @(posedge clk); while (!hit.valid);
            sb.check_result(hit.is_hit, hit.hit_distance);
        end
    end

    initial
    begin
        sb = new();
        sb.reset_regs();
        hold_off = 0;
        stall_free = 0;
        sent = 0;
        rst_n = 0;
        ray.valid = 0;
        ray.origin_x = 0;
        ray.origin_y = 0;
        ray.origin_z = 0;
        ray.dir_x = 0;
        ray.dir_y = 0;
        ray.dir_z = 0;
        ray.limit_enable = 0;
        ray.max_distance = 0;
        cfg.valid = 0;
        cfg.index = 0;
        cfg.data = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed rays against the reset sphere, then a huge one and a zero-radius one
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 0, 0, 0, 0);          // plain hit
        send_ray(0, 0, 0, 16'sd16384, 0, 0, 0, 0);                   // origin inside
        send_ray(1 << 16, 0, 0, 16'sd16384, 0, 0, 0, 0);             // origin on surface
        send_ray(5 << 16, 0, 0, 16'sd16384, 0, 0, 0, 0);             // center behind
        send_ray(0, 5 << 16, 0, 16'sd16384, 0, 0, 0, 0);             // projection zero
        send_ray(-(5 << 16), 1 << 16, 0, 16'sd16384, 0, 0, 0, 0);    // grazing
        send_ray(-(5 << 16), 2 << 16, 0, 16'sd16384, 0, 0, 0, 0);    // passes by
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 0, 0, 1, 4 << 16);    // at the limit
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 0, 0, 1, (4 << 16) + 1);
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 0, 0, 1, 0);
        send_ray(-(5 << 16), 0, 0, 16'sh7fff, 16'sh7fff, 0, 0, 0);   // off-unit dir
        send_ray(-(5 << 16), 0, 0, 16'sh8000, 0, 0, 0, 0);
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 16'sh8000, 16'sh7fff, 1, 32'hffff_ffff);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 16'sd9459, 16'sd9459, 16'sd9459, 0, 0);
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 -16'sd16384, 0, 0, 0, 0);
        drain();
        write_reg(REG_RADIUS, 32'h7fff_ffff);                       // huge sphere
        write_reg(REG_CENTER_X, 32'h7fff_ffff);
        write_reg(REG_CENTER_Y, 32'h8000_0000);
        write_reg(REG_CENTER_Z, 32'h7fff_ffff);
        send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 16'sd9459, -16'sd9459, 16'sd9459, 0, 0);              // saturates
        send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 16'sd9459, -16'sd9459, 16'sd9459, 1, 32'hffff_ffff);
        send_ray(32'h8000_0000, 0, 0, 16'sd16384, 0, 0, 0, 0);
        drain();
        write_reg(REG_RADIUS, 0);                                   // zero radius
        write_reg(REG_CENTER_X, 0);
        write_reg(REG_CENTER_Y, 0);
        write_reg(REG_CENTER_Z, 0);
        send_ray(-(5 << 16), 0, 0, 16'sd16384, 0, 0, 0, 0);
        send_ray(0, 0, 0, 16'sd16384, 0, 0, 0, 0);
        drain();

        // random phases, each with its own sphere
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CENTER_X, ph == 5 ? 32'h8000_0000 : rand_coord());
            write_reg(REG_CENTER_Y, ph == 5 ? 32'h7fff_ffff : rand_coord());
            write_reg(REG_CENTER_Z, rand_coord());
            write_reg(REG_RADIUS, ph == 0 ? 32'd1 : ph == 5 ? 32'h7fff_ffff
                                  : $urandom_range(1 << 14, 8 << 16));
            stall_free = (ph == 2);
            if (ph == 3)
                hold_off = 300;     // let the pipeline back up into the input
            for (int n = 0; n < 155; n++) begin
                send_random();
                if (ph == 4 && n == 70)
                    drain();        // sender waits for everything outstanding
            end
            drain();
        end

        $display("%0d rays sent over 9 sphere settings, %0d hits and %0d misses checked",
                 sent, sb.hits, sb.misses);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ ray_sphere_hit_distance_core.f @@
design/rshd_pkg.sv
design/rshd_ray_if.sv
design/rshd_hit_if.sv
design/rshd_cfg_if.sv
design/rshd_front.sv
design/rshd_sqrt.sv
design/ray_sphere_hit_distance_core.sv
tb/sv/tb_ray_sphere_hit_distance_core.sv
